// ===== sv/kpt_pkg.sv =====
// shared types and constants of the keyframe playback timer
package kpt_pkg;

	// default table depth
	localparam int MAX_FRAMES_DEF = 256;

	// field and datapath widths
	localparam int DUR_W  = 31;
	localparam int TIME_W = 32;
	localparam int RATE_W = 16;
	localparam int FC_W   = 9;
	localparam int T_W    = 48;
	localparam int DVD_W  = 48;
	localparam int FRAC_W = 16;

	// blend weight constants, q1.16
	localparam logic [16:0] WEIGHT_ONE  = 17'd65536;
	localparam logic [16:0] WEIGHT_HALF = 17'd32768;

	// register reset values
	localparam logic              LOOP_RST   = 1'b1;
	localparam logic [RATE_W-1:0] RATE_RST   = 16'd256;
	localparam logic [FC_W-1:0]   FCOUNT_RST = 9'd1;

	// item kinds
	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_TICK = 2'd1,
		KIND_PLAY = 2'd2,
		KIND_STOP = 2'd3
	} kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_LOOP_MODE   = 2'd0,
		REG_PLAY_RATE   = 2'd1,
		REG_FRAME_COUNT = 2'd2
	} reg_idx_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_MOVE,
		ST_SUM,
		ST_CHECK,
		ST_MOD,
		ST_SAT,
		ST_WALK,
		ST_FRAC,
		ST_FIN,
		ST_DONE
	} state_t;

	// one result item
	typedef struct packed {
		logic [7:0]         current_frame;
		logic [7:0]         following_frame;
		logic [16:0]        blend_weight;
		logic signed [31:0] elapsed_time;
		logic               is_playing;
		logic               ended;
		logic [7:0]         bounds_frame;
	} res_t;

endpackage

// ===== sv/keyframe_playback_timer.sv =====
// keyframe playback timer top level: configuration registers and output register
//
// Input channel (in_valid/in_ready) takes one item of kind load, tick, play or
// stop; every item gives exactly one result item on the output channel
// (out_valid/out_ready) with the frame pair, blend weight, time and flags.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) for
// loop_mode, play_rate and frame_count; write it only while the block is idle.
// Load, stop and idle ticks go straight to the result state and then to the
// output register. A moving tick or play takes more steps: the duration table
// is read once per cycle to sum the length, the shared 48-step restoring
// divider runs for the loop wrap when the time leaves the range in loop mode,
// the table is walked again to find the frame, and the divider runs again for
// the blend fraction. The block takes one item at a time; in_ready is low
// while an item is being worked.
// Reset clears the playback state (time 0, frame 0, weight 0, stopped) and
// sets loop_mode 1, play_rate 1.0 and one frame; table entries hold nothing
// until loaded. A finished result waits in the output register while the
// next item is accepted; if the receiver stalls, the sequencer holds its
// following result until that register is free.
module keyframe_playback_timer #(
	parameter int MAX_FRAMES = kpt_pkg::MAX_FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  kind,
	input  logic [7:0]                  frame_index,
	input  logic [30:0]                 frame_duration,
	input  logic signed [31:0]          time_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  current_frame,
	output logic [7:0]                  following_frame,
	output logic [16:0]                 blend_weight,
	output logic signed [31:0]          elapsed_time,
	output logic                        is_playing,
	output logic                        ended,
	output logic [7:0]                  bounds_frame,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [15:0]                 cfg_data
);

	localparam int CNT_W = $clog2(MAX_FRAMES + 1);

	logic                          loop_q;
	logic signed [15:0]            rate_q;
	logic [kpt_pkg::FC_W-1:0]      fcount_q;
	logic [CNT_W-1:0]              n_frames;
	logic                          out_valid_q;
	kpt_pkg::res_t                 res_q;
	kpt_pkg::res_t                 res;
	logic                          res_push;
	logic                          slot_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q   <= kpt_pkg::LOOP_RST;
			rate_q   <= kpt_pkg::RATE_RST;
			fcount_q <= kpt_pkg::FCOUNT_RST;
		end else if (cfg_we) begin
			unique case (kpt_pkg::reg_idx_t'(cfg_index))
				kpt_pkg::REG_LOOP_MODE:   loop_q   <= cfg_data[0];
				kpt_pkg::REG_PLAY_RATE:   rate_q   <= cfg_data;
				kpt_pkg::REG_FRAME_COUNT: fcount_q <= cfg_data[kpt_pkg::FC_W-1:0];
				default: ;
			endcase
		end
	end

	// active frame count, clamped to 1..MAX_FRAMES
	always_comb begin
		if (fcount_q == '0)
			n_frames = CNT_W'(1);
		else if (32'(fcount_q) > 32'(MAX_FRAMES))
			n_frames = CNT_W'(MAX_FRAMES);
		else
			n_frames = CNT_W'(fcount_q);
	end

	kpt_core #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.frame_index    (frame_index),
		.frame_duration (frame_duration),
		.time_value     (time_value),
		.loop_mode      (loop_q),
		.play_rate      (rate_q),
		.n_frames       (n_frames),
		.slot_free      (slot_free),
		.res_push       (res_push),
		.res            (res)
	);

	// output register
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign current_frame   = res_q.current_frame;
	assign following_frame = res_q.following_frame;
	assign blend_weight    = res_q.blend_weight;
	assign elapsed_time    = res_q.elapsed_time;
	assign is_playing      = res_q.is_playing;
	assign ended           = res_q.ended;
	assign bounds_frame    = res_q.bounds_frame;

endmodule

// ===== sv/kpt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module kpt_div #(
	parameter int DVS_W = 39
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [kpt_pkg::DVD_W-1:0]   dividend,
	input  logic [DVS_W-1:0]            divisor,
	output logic                        done,
	output logic [kpt_pkg::DVD_W-1:0]   quotient,
	output logic [DVS_W-1:0]            remainder
);

	localparam int DVD_W  = kpt_pkg::DVD_W;
	localparam int CNT_DW = $clog2(DVD_W + 1);

	logic [CNT_DW-1:0] cnt_q;
	logic              done_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W:0]    sh;
	logic [DVS_W:0]    diff;
	logic              ge;

	// shift in next dividend bit and trial subtract
	always_comb begin
		sh   = {rem_q, dvd_q[DVD_W-1]};
		diff = sh - {1'b0, dvs_q};
		ge   = (sh >= {1'b0, dvs_q});
	end

	// step counter and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_DW'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_DW'(1));
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

// ===== sv/kpt_core.sv =====
// playback sequencer: duration table, time update, frame walk and blend weight
module kpt_core #(
	parameter int MAX_FRAMES = kpt_pkg::MAX_FRAMES_DEF,
	localparam int CNT_W = $clog2(MAX_FRAMES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [7:0]                    frame_index,
	input  logic [kpt_pkg::DUR_W-1:0]     frame_duration,
	input  logic signed [31:0]            time_value,
	input  logic                          loop_mode,
	input  logic signed [15:0]            play_rate,
	input  logic [CNT_W-1:0]              n_frames,
	input  logic                          slot_free,
	output logic                          res_push,
	output kpt_pkg::res_t                 res
);

	localparam int IDX_W = $clog2(MAX_FRAMES);
	localparam int DUR_W = kpt_pkg::DUR_W;
	localparam int LEN_W = DUR_W + IDX_W;
	localparam int T_W   = kpt_pkg::T_W;
	localparam int DVD_W = kpt_pkg::DVD_W;

	kpt_pkg::state_t state_q, state_d;

	logic                    running_q;
	logic                    ended_q;
	logic signed [31:0]      pos_q;
	logic [IDX_W-1:0]        frame_now_q;
	logic [IDX_W-1:0]        frame_after_q;
	logic [16:0]             weight_q;
	logic signed [32:0]      delta_q;
	logic signed [48:0]      prod_q;
	logic signed [T_W-1:0]   t_q;
	logic [LEN_W-1:0]        len_q;
	logic [LEN_W-1:0]        acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    rv_q;
	logic [IDX_W-1:0]        ridx_q;
	logic [DUR_W-1:0]        rdata_q;
	logic [DUR_W-1:0]        mem [MAX_FRAMES];

	logic                    accept;
	logic                    mem_we;
	logic [IDX_W-1:0]        raddr;
	logic                    issue;
	logic signed [48:0]      prod_adj;
	logic signed [40:0]      move_w;
	logic signed [T_W-1:0]   t_sum;
	logic signed [T_W-1:0]   len_ext;
	logic signed [T_W-1:0]   pos_ext;
	logic                    out_range;
	logic [DVD_W-1:0]        t_abs;
	logic [LEN_W-1:0]        acc_nx;
	logic                    hit;
	logic signed [T_W-1:0]   offset_w;
	logic [LEN_W-1:0]        mod_t;
	logic signed [31:0]      sat_w;
	logic [CNT_W-1:0]        next_idx;
	logic [IDX_W-1:0]        last_idx;
	logic                    div_start;
	logic [DVD_W-1:0]        div_dvd;
	logic [LEN_W-1:0]        div_dvs;
	logic                    div_done;
	logic [DVD_W-1:0]        div_quo;
	logic [LEN_W-1:0]        div_rem;

	assign in_ready = (state_q == kpt_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign mem_we   = accept && (kpt_pkg::kind_t'(kind) == kpt_pkg::KIND_LOAD) &&
		(32'(frame_index) < 32'(MAX_FRAMES));
	assign raddr    = cnt_q[IDX_W-1:0];
	assign issue    = ((state_q == kpt_pkg::ST_SUM) || (state_q == kpt_pkg::ST_WALK)) &&
		(cnt_q < n_frames);

	// datapath terms
	always_comb begin
		// rate times delta over 256, truncated toward zero
		prod_adj  = prod_q + $signed({41'd0, {8{prod_q[48]}}});
		move_w    = prod_adj[48:8];
		pos_ext   = $signed({{(T_W-32){pos_q[31]}}, pos_q});
		t_sum     = pos_ext + $signed({{(T_W-41){move_w[40]}}, move_w});
		len_ext   = $signed({{(T_W-LEN_W){1'b0}}, len_q});
		out_range = (t_q > len_ext) || t_q[T_W-1] || (t_q == '0);
		t_abs     = t_q[T_W-1] ? DVD_W'(-t_q) : DVD_W'(t_q);
		// frame walk
		acc_nx    = acc_q + LEN_W'(rdata_q);
		hit       = (pos_ext <= $signed({{(T_W-LEN_W){1'b0}}, acc_nx}));
		offset_w  = pos_ext - $signed({{(T_W-LEN_W){1'b0}}, acc_q});
		// floor modulo from the magnitude remainder
		mod_t     = (t_q[T_W-1] && (div_rem != '0)) ? (len_q - div_rem) : div_rem;
		// saturate to 32 bits
		if (t_q > $signed(T_W'(32'h7FFF_FFFF)))
			sat_w = 32'sh7FFF_FFFF;
		else if (t_q < $signed({{(T_W-31){1'b1}}, 31'd0}))
			sat_w = $signed(32'h8000_0000);
		else
			sat_w = t_q[31:0];
		next_idx  = CNT_W'(frame_now_q) + 1'b1;
		last_idx  = IDX_W'(n_frames - 1'b1);
		// divider operands
		div_dvd   = (state_q == kpt_pkg::ST_CHECK) ? t_abs :
			{offset_w[31:0], {kpt_pkg::FRAC_W{1'b0}}};
		div_dvs   = (state_q == kpt_pkg::ST_CHECK) ? len_q : LEN_W'(rdata_q);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		res_push  = 1'b0;
		unique case (state_q)
			kpt_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (kpt_pkg::kind_t'(kind))
						kpt_pkg::KIND_LOAD: state_d = kpt_pkg::ST_DONE;
						kpt_pkg::KIND_STOP: state_d = kpt_pkg::ST_DONE;
						kpt_pkg::KIND_TICK: state_d = running_q ? kpt_pkg::ST_MUL :
							kpt_pkg::ST_DONE;
						kpt_pkg::KIND_PLAY: state_d = kpt_pkg::ST_MUL;
						default: state_d = kpt_pkg::ST_DONE;
					endcase
				end
			end
			kpt_pkg::ST_MUL: state_d = kpt_pkg::ST_MOVE;
			kpt_pkg::ST_MOVE: begin
				state_d = (move_w == '0) ? kpt_pkg::ST_DONE : kpt_pkg::ST_SUM;
			end
			kpt_pkg::ST_SUM: begin
				if (!issue && !rv_q) state_d = kpt_pkg::ST_CHECK;
			end
			kpt_pkg::ST_CHECK: begin
				if (out_range && loop_mode && (len_q != '0)) begin
					div_start = 1'b1;
					state_d   = kpt_pkg::ST_MOD;
				end else begin
					state_d = kpt_pkg::ST_SAT;
				end
			end
			kpt_pkg::ST_MOD: begin
				if (div_done) state_d = kpt_pkg::ST_SAT;
			end
			kpt_pkg::ST_SAT: state_d = kpt_pkg::ST_WALK;
			kpt_pkg::ST_WALK: begin
				if (rv_q && hit) begin
					if (rdata_q == '0) begin
						state_d = kpt_pkg::ST_FIN;
					end else begin
						div_start = 1'b1;
						state_d   = kpt_pkg::ST_FRAC;
					end
				end else if (!issue && !rv_q) begin
					state_d = kpt_pkg::ST_FIN;
				end
			end
			kpt_pkg::ST_FRAC: begin
				if (div_done) state_d = kpt_pkg::ST_FIN;
			end
			kpt_pkg::ST_FIN: state_d = kpt_pkg::ST_DONE;
			kpt_pkg::ST_DONE: begin
				if (slot_free) begin
					res_push = 1'b1;
					state_d  = kpt_pkg::ST_IDLE;
				end
			end
			default: state_d = kpt_pkg::ST_IDLE;
		endcase
	end

	// playback state and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			ended_q       <= 1'b0;
			pos_q         <= '0;
			frame_now_q   <= '0;
			frame_after_q <= '0;
			weight_q      <= '0;
			cnt_q         <= '0;
			rv_q          <= 1'b0;
		end else begin
			rv_q <= issue;
			if (issue) cnt_q <= cnt_q + 1'b1;
			unique case (state_q)
				kpt_pkg::ST_IDLE: begin
					if (accept) begin
						ended_q <= 1'b0;
						if (kpt_pkg::kind_t'(kind) == kpt_pkg::KIND_PLAY) running_q <= 1'b1;
						if (kpt_pkg::kind_t'(kind) == kpt_pkg::KIND_STOP) running_q <= 1'b0;
					end
				end
				kpt_pkg::ST_MOVE: cnt_q <= '0;
				kpt_pkg::ST_CHECK: begin
					if (out_range && !loop_mode) begin
						running_q <= 1'b0;
						ended_q   <= 1'b1;
					end
				end
				kpt_pkg::ST_SAT: begin
					pos_q <= sat_w;
					cnt_q <= '0;
				end
				kpt_pkg::ST_WALK: begin
					if (rv_q && hit) begin
						frame_now_q <= ridx_q;
						if (rdata_q == '0) weight_q <= kpt_pkg::WEIGHT_ONE;
					end else if (!issue && !rv_q) begin
						frame_now_q <= last_idx;
						weight_q    <= '0;
					end
				end
				kpt_pkg::ST_FRAC: begin
					if (div_done) begin
						weight_q <= (div_quo > DVD_W'(kpt_pkg::WEIGHT_ONE)) ? 17'd0 :
							kpt_pkg::WEIGHT_ONE - div_quo[16:0];
					end
				end
				kpt_pkg::ST_FIN: begin
					if (next_idx >= n_frames)
						frame_after_q <= loop_mode ? '0 : frame_now_q;
					else
						frame_after_q <= next_idx[IDX_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// arithmetic payload registers
	always_ff @(posedge clk) begin
		ridx_q <= raddr;
		if (accept) begin
			if (kpt_pkg::kind_t'(kind) == kpt_pkg::KIND_PLAY)
				delta_q <= $signed({time_value[31], time_value}) - $signed({pos_q[31], pos_q});
			else
				delta_q <= $signed({time_value[31], time_value});
		end
		if (state_q == kpt_pkg::ST_MUL) prod_q <= play_rate * delta_q;
		if (state_q == kpt_pkg::ST_MOVE) begin
			t_q   <= t_sum;
			len_q <= '0;
		end
		if ((state_q == kpt_pkg::ST_SUM) && rv_q) len_q <= acc_nx - acc_q + len_q;
		if (state_q == kpt_pkg::ST_CHECK && out_range) begin
			if (!loop_mode) t_q <= len_ext;
			else if (len_q == '0) t_q <= '0;
		end
		if ((state_q == kpt_pkg::ST_MOD) && div_done)
			t_q <= $signed({{(T_W-LEN_W){1'b0}}, mod_t});
		if (state_q == kpt_pkg::ST_SAT) acc_q <= '0;
		if ((state_q == kpt_pkg::ST_WALK) && rv_q && !hit) acc_q <= acc_nx;
	end

	// duration table
	always_ff @(posedge clk) begin
		if (mem_we) mem[IDX_W'(frame_index)] <= frame_duration;
		rdata_q <= mem[raddr];
	end

	// shared divider for wrap modulo and frame fraction
	kpt_div #(
		.DVS_W(LEN_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// result item
	always_comb begin
		res.current_frame   = 8'(frame_now_q);
		res.following_frame = 8'(frame_after_q);
		res.blend_weight    = weight_q;
		res.elapsed_time    = pos_q;
		res.is_playing      = running_q;
		res.ended           = ended_q;
		res.bounds_frame    = (weight_q > kpt_pkg::WEIGHT_HALF) ? 8'(frame_after_q) :
			8'(frame_now_q);
	end

	// checks
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		weight_q <= kpt_pkg::WEIGHT_ONE)
		else $error("blend weight above one");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready right after an accepted item");

	a_ended_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !running_q)
		else $error("ended while still running");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == kpt_pkg::ST_MOD || state_q == kpt_pkg::ST_FRAC))
		else $error("divider finished outside a waiting state");

endmodule

// ===== sim/keyframe_playback_timer_tb.sv =====
// self-checking testbench for the keyframe playback timer
`timescale 1ns / 100ps

module keyframe_playback_timer_tb;
	import kpt_pkg::*;

	localparam int FRAMES_MAX = MAX_FRAMES_DEF;
	localparam int DRAIN_CYC  = 700;
	localparam longint T_MAX  = 64'sd2147483647;
	localparam longint T_MIN  = -T_MAX - 1;
	localparam int MSG_LIMIT  = 10;

	// one input item
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         idx;
		logic [30:0]        dur;
		logic signed [31:0] tval;
	} cmd_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	cmd_t     cmd_cur = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	logic     cfg_we = 1'b0;
	reg_idx_t cfg_index = REG_LOOP_MODE;
	logic [15:0] cfg_data = '0;

	logic [7:0]         current_frame;
	logic [7:0]         following_frame;
	logic [16:0]        blend_weight;
	logic signed [31:0] elapsed_time;
	logic               is_playing;
	logic               ended;
	logic [7:0]         bounds_frame;

	cmd_t cmd_q[$];
	res_t frame_state_q[$];
	logic in_fire = 1'b0;
	int   idle_pct = 20;
	int   err_cnt = 0;
	int   res_seen = 0;
	bit   tab_loaded [FRAMES_MAX];

	// predicted block state and register copies
	logic [30:0] dur_tab [FRAMES_MAX];
	int pos_now = 0;
	int frm_cur = 0;
	int frm_next = 0;
	int wgt_cur = 0;
	bit run_flag = 1'b0;
	bit loop_cfg = LOOP_RST;
	int rate_cfg = int'($signed(RATE_RST));
	int fcount_cfg = int'(FCOUNT_RST);

	keyframe_playback_timer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (cmd_cur.kind),
		.frame_index    (cmd_cur.idx),
		.frame_duration (cmd_cur.dur),
		.time_value     (cmd_cur.tval),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.current_frame  (current_frame),
		.following_frame(following_frame),
		.blend_weight   (blend_weight),
		.elapsed_time   (elapsed_time),
		.is_playing     (is_playing),
		.ended          (ended),
		.bounds_frame   (bounds_frame),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// clock
	always #1 clk = ~clk;

	// number of frames the walk covers
	function automatic int frames_used();
		int n;
		n = fcount_cfg;
		if (n == 0) n = 1;
		if (n > FRAMES_MAX) n = FRAMES_MAX;
		return n;
	endfunction

	// move the playback position, wrap or clamp it, then find the frame and blend
	function automatic bit move_position(longint mv, longint dl);
		longint total, t, acc, d, w;
		int n, i, sel;
		bit hit, found;
		hit = 1'b0;
		found = 1'b0;
		total = 0;
		acc = 0;
		w = 0;
		n = frames_used();
		sel = n - 1;
		if (mv == 0 || dl == 0) return 1'b0;
		for (i = 0; i < n; i++) total += longint'(dur_tab[i]);
		t = longint'(pos_now) + mv;
		// past the end or at/below zero
		if (t > total || t <= 0) begin
			if (loop_cfg) begin
				if (total == 0) begin
					t = 0;
				end else begin
					t = t % total;
					if (t < 0) t += total;
				end
			end else begin
				t = total;
				run_flag = 1'b0;
				hit = 1'b1;
			end
		end
		if (t > T_MAX) t = T_MAX;
		if (t < T_MIN) t = T_MIN;
		pos_now = int'(t);
		// walk the durations for the frame holding t
		for (i = 0; i < n; i++) begin
			if (!found) begin
				d = longint'(dur_tab[i]);
				acc += d;
				if (t <= acc) begin
					found = 1'b1;
					sel = i;
					if (d == 0) begin
						w = 65536;
					end else begin
						w = 65536 - ((t - (acc - d)) * 65536) / d;
						if (w < 0) w = 0;
						if (w > 65536) w = 65536;
					end
				end
			end
		end
		frm_cur = sel;
		wgt_cur = int'(w);
		if (sel + 1 >= n) frm_next = loop_cfg ? 0 : sel;
		else frm_next = sel + 1;
		return hit;
	endfunction

	// apply one accepted item and queue the frame state it should produce
	function automatic void predict_frame_state(cmd_t c);
		longint tv, dl, mv;
		bit fin;
		res_t r;
		fin = 1'b0;
		tv = longint'($signed(c.tval));
		case (c.kind)
			KIND_LOAD: begin
				dur_tab[c.idx] = c.dur;
			end
			KIND_TICK: begin
				if (run_flag) begin
					mv = (longint'(rate_cfg) * tv) / 256;
					fin = move_position(mv, tv);
				end
			end
			KIND_PLAY: begin
				dl = tv - longint'(pos_now);
				mv = (longint'(rate_cfg) * dl) / 256;
				run_flag = 1'b1;
				fin = move_position(mv, dl);
			end
			default: begin
				run_flag = 1'b0;
			end
		endcase
		r.current_frame = frm_cur[7:0];
		r.following_frame = frm_next[7:0];
		r.blend_weight = wgt_cur[16:0];
		r.elapsed_time = pos_now;
		r.is_playing = run_flag;
		r.ended = fin;
		r.bounds_frame = (wgt_cur[16:0] > WEIGHT_HALF) ? frm_next[7:0] : frm_cur[7:0];
		frame_state_q.push_back(r);
	endfunction

	task automatic flag_error(string msg);
		err_cnt++;
		if (err_cnt <= MSG_LIMIT) $display("[%0t] result %0d: %s", $time, res_seen, msg);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) flag_error($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	// input acceptance and result checking
	always @(posedge clk) begin
		res_t want;
		in_fire <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) predict_frame_state(cmd_cur);
		if (arst_n && out_valid && out_ready) begin
			if (frame_state_q.size() == 0) begin
				flag_error("result with nothing expected");
			end else begin
				want = frame_state_q.pop_front();
				check_field("current_frame", want.current_frame, current_frame);
				check_field("following_frame", want.following_frame, following_frame);
				check_field("blend_weight", want.blend_weight, blend_weight);
				check_field("elapsed_time", $signed(want.elapsed_time), elapsed_time);
				check_field("is_playing", want.is_playing, is_playing);
				check_field("ended", want.ended, ended);
				check_field("bounds_frame", want.bounds_frame, bounds_frame);
			end
			res_seen++;
		end
	end

	// item driver and result back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				cmd_cur <= cmd_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(0, 99) >= idle_pct);
	end

	task automatic queue_cmd(kind_t kd, int ix, logic [30:0] du, logic [31:0] tv);
		cmd_t c;
		c.kind = kd;
		c.idx = ix[7:0];
		c.dur = du;
		c.tval = tv;
		if (kd == KIND_LOAD) tab_loaded[ix] = 1'b1;
		cmd_q.push_back(c);
	endtask

	function automatic logic [30:0] pick_duration(int k);
		logic [31:0] hi;
		if ($urandom_range(0, 19) == 0) return 31'($urandom_range(1, 32'h7FFFFFFF));
		hi = (32'd1 << k) - 1;
		return 31'($urandom_range(1, hi));
	endfunction

	// random time value of up to b magnitude bits, sometimes negated or fully random
	function automatic logic [31:0] pick_time(int b);
		logic [31:0] v, mask;
		int w;
		if ($urandom_range(0, 9) == 0) return $urandom;
		w = $urandom_range(0, (b > 32) ? 32 : b);
		mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
		v = $urandom & mask;
		if ($urandom_range(0, 3) == 0) v = -v;
		return v;
	endfunction

	task automatic write_reg(reg_idx_t ri, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_data <= val;
		case (ri)
			REG_LOOP_MODE:   loop_cfg = val[0];
			REG_PLAY_RATE:   rate_cfg = int'($signed(val));
			REG_FRAME_COUNT: fcount_cfg = int'(val[8:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every item is in and every result is out
	task automatic drain(int extra);
		while (cmd_q.size() != 0 || in_valid || frame_state_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// one configuration phase: fill entries not yet loaded, then mostly playback traffic
	task automatic gen_phase(int n, int k, int target);
		int cnt, sel, ix, i;
		cnt = 0;
		for (i = 0; i < n; i++) begin
			if (!tab_loaded[i]) queue_cmd(KIND_LOAD, i, pick_duration(k), $urandom);
		end
		while (cnt < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				ix = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
				queue_cmd(KIND_LOAD, ix, pick_duration(k), $urandom);
			end else if (sel < 25) begin
				queue_cmd(KIND_PLAY, $urandom_range(0, 255), 31'($urandom),
					pick_time(k + $clog2(n) + 1));
			end else if (sel < 31) begin
				queue_cmd(KIND_STOP, $urandom_range(0, 255), 31'($urandom), $urandom);
			end else begin
				queue_cmd(KIND_TICK, $urandom_range(0, 255), 31'($urandom), pick_time(k));
			end
			cnt++;
		end
	endtask

	// stimulus sequence
	initial begin
		int fc_plan [10];
		int rate_plan [10];
		int ph, n, k;
		logic [15:0] word;
		fc_plan = '{3, 0, 16, 256, 7, 1, 511, 2, 12, 5};
		rate_plan = '{256, -32768, 32767, 128, 0, -256, 512, 384, -100, 256};
		foreach (dur_tab[i]) dur_tab[i] = '0;
		foreach (tab_loaded[i]) tab_loaded[i] = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: one looping frame at normal speed
		queue_cmd(KIND_TICK, 0, 31'd5, 32'h1234_5678);
		queue_cmd(KIND_STOP, 0, 31'd5, 32'd0);
		queue_cmd(KIND_LOAD, 0, 31'd1, 32'd0);
		queue_cmd(KIND_LOAD, 255, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(KIND_LOAD, 0, 31'h1_0000, 32'd0);
		queue_cmd(KIND_PLAY, 0, 31'd1, 32'd0);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'd0);
		queue_cmd(KIND_PLAY, 0, 31'd1, 32'h4000);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'h4000);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'd1);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'hFFFF_FFFF);
		queue_cmd(KIND_PLAY, 0, 31'd1, 32'h1_0000);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'h7FFF_FFFF);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'h8000_0000);
		queue_cmd(KIND_PLAY, 0, 31'd1, -32'sd5);
		queue_cmd(KIND_PLAY, 0, 31'd1, 32'h7FFF_FFFF);
		queue_cmd(KIND_STOP, 0, 31'd1, 32'd0);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'h100);
		drain(4);

		// play once over two frames: cross a frame, run off the end, underflow
		write_reg(REG_LOOP_MODE, 16'hFFFE);
		write_reg(REG_PLAY_RATE, 16'd256);
		write_reg(REG_FRAME_COUNT, 16'd2);
		queue_cmd(KIND_LOAD, 1, 31'h2_0000, 32'd0);
		queue_cmd(KIND_PLAY, 0, 31'd1, 32'h8000);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'h1_0000);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'h4_0000);
		queue_cmd(KIND_TICK, 0, 31'd1, 32'h100);
		queue_cmd(KIND_PLAY, 0, 31'd1, -32'sh100);
		drain(4);

		// random phases over a spread of settings
		for (ph = 0; ph < 10; ph++) begin
			if (ph == 8) rate_plan[ph] = $urandom_range(0, 65535) - 32768;
			word = 16'($urandom);
			write_reg(REG_LOOP_MODE, {word[15:1], 1'(ph % 2)});
			write_reg(REG_PLAY_RATE, 16'(rate_plan[ph]));
			word = 16'($urandom);
			write_reg(REG_FRAME_COUNT, {word[15:9], 9'(fc_plan[ph])});
			n = frames_used();
			k = (ph % 3 == 1) ? 31 : $urandom_range(2, 24);
			idle_pct = (ph == 4) ? 0 : 20;
			gen_phase(n, k, (n >= 64) ? 40 : 110);
			drain(4);
		end

		drain(DRAIN_CYC);
		if (err_cnt == 0) begin
			$display("[keyframe_playback_timer] OK");
		end else begin
			$display("[keyframe_playback_timer] ERROR");
		end
		$finish;
	end

	// hang guard
	initial begin
		#4000000;
		$display("[keyframe_playback_timer] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/kpt_pkg.sv
sv/kpt_div.sv
sv/kpt_core.sv
sv/keyframe_playback_timer.sv
sim/keyframe_playback_timer_tb.sv
